### src/mmcf_pkg.sv
// Shared constants, codes and controller/datapath interface types for the mean cycle finder.
package mmcf_pkg;

	localparam int MAX_NODES  = 32;
	localparam int NODE_W     = 5;
	localparam int LVL_W      = 6;
	localparam int WEIGHT_W   = 32;
	localparam int COST_W     = 41;
	localparam int DIFF_W     = 42;
	localparam int SUM_W      = 40;
	localparam int PROD_W     = DIFF_W + LVL_W + 1;
	localparam int EDGE_AW    = 2 * NODE_W;
	localparam int EDGE_DEPTH = MAX_NODES * MAX_NODES;
	localparam int WALK_AW    = LVL_W + NODE_W;
	localparam int WALK_DEPTH = (MAX_NODES + 1) * MAX_NODES;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic               edge_we;
		logic               clr_we;
		logic [EDGE_AW-1:0] clr_addr;
		logic               init_we;
		logic               bld_rd;
		logic               bld_first;
		logic               bld_wr;
		logic               top_rd;
		logic               top_ld;
		logic               srch_rd;
		logic               srch_ev;
		logic               srch_mul;
		logic               srch_cmp;
		logic               best_clr;
		logic               cur_ld_i;
		logic               cur_ld_best;
		logic               out_rd;
		logic               out_cur_ld;
		logic               emit;
		logic               emit_none;
		logic               emit_last;
		logic [LVL_W-1:0]   nv;
		logic [LVL_W-1:0]   k;
		logic [NODE_W-1:0]  a;
		logic [NODE_W-1:0]  b;
		logic [LVL_W-1:0]   s;
		logic [NODE_W-1:0]  i;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic             top_reach;
		logic             best_valid;
		logic [LVL_W-1:0] best_k;
	} stat_t;

endpackage

### src/min_mean_cycle_finder_core.sv
// Top level of the minimum mean cycle finder: controller plus datapath.
// After reset all edge store entries are swept clear with busy high.
// Edge write: accepted while idle, busy stays low, no result.
// Run (V nodes): the walk table is walked one source node per cycle, pausing for a
// write after each destination, while the walks are built; L is the cycle length.
// Results come as L+1 strobes (or one with found=0); the receiver cannot stall.
module min_mean_cycle_finder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 cmd,
	input  logic [mmcf_pkg::NODE_W-1:0]          from_node,
	input  logic [mmcf_pkg::NODE_W-1:0]          to_node,
	input  logic signed [mmcf_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                 edge_present,
	input  logic                                 node_count_we,
	input  logic [mmcf_pkg::LVL_W-1:0]           node_count,
	output logic                                 result_valid,
	output logic                                 found,
	output logic [mmcf_pkg::NODE_W-1:0]          cycle_node,
	output logic signed [mmcf_pkg::SUM_W-1:0]    cycle_weight,
	output logic [mmcf_pkg::LVL_W-1:0]           cycle_length,
	output logic                                 last
);
	import mmcf_pkg::*;

	ctrl_t ctl;   // sequencer commands
	stat_t st;    // datapath status back to the sequencer

	// controller: owns loop counters (level, source, destination, search node)
	mmcf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.node_count_we (node_count_we),
		.node_count    (node_count),
		.busy          (busy),
		.ctl           (ctl),
		.st            (st)
	);

	// datapath: memories, relaxation, exact ratio compare, result register
	mmcf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.from_node    (from_node),
		.to_node      (to_node),
		.edge_weight  (edge_weight),
		.edge_present (edge_present),
		.result_valid (result_valid),
		.found        (found),
		.cycle_node   (cycle_node),
		.cycle_weight (cycle_weight),
		.cycle_length (cycle_length),
		.last         (last)
	);

endmodule

### src/mmcf_ctrl.sv
// Sequencer for edge store clear, walk table build, candidate search and cycle output.
module mmcf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        cmd,
	input  logic                        node_count_we,
	input  logic [mmcf_pkg::LVL_W-1:0]  node_count,
	output logic                        busy,
	output mmcf_pkg::ctrl_t             ctl,
	input  mmcf_pkg::stat_t             st
);
	import mmcf_pkg::*;

	typedef enum logic [13:0] {
		ST_CLEAR  = 14'b00000000000001,
		ST_IDLE   = 14'b00000000000010,
		ST_INIT   = 14'b00000000000100,
		ST_B_RD   = 14'b00000000001000,
		ST_B_WR   = 14'b00000000010000,
		ST_SI_RD  = 14'b00000000100000,
		ST_SI_CHK = 14'b00000001000000,
		ST_SK_RD  = 14'b00000010000000,
		ST_SK_EV  = 14'b00000100000000,
		ST_SK_MUL = 14'b00001000000000,
		ST_SK_CMP = 14'b00010000000000,
		ST_O_INIT = 14'b00100000000000,
		ST_O_EMIT = 14'b01000000000000,
		ST_O_WAIT = 14'b10000000000000
	} state_t;

	state_t             state_q;
	logic [LVL_W-1:0]   nc_q, nv_q, k_q, s_q;
	logic [NODE_W-1:0]  a_q, b_q, i_q;
	logic [EDGE_AW-1:0] clr_q;
	logic [LVL_W-1:0]   nv_m1;
	logic               a_last, b_last, i_last, k_last, at_best;

	assign nv_m1   = nv_q - LVL_W'(1);
	assign a_last  = ({1'b0, a_q} == nv_m1);
	assign b_last  = ({1'b0, b_q} == nv_m1);
	assign i_last  = ({1'b0, i_q} == nv_m1);
	assign k_last  = (k_q == nv_m1);
	assign at_best = (s_q == st.best_k);
	assign busy    = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			nc_q    <= LVL_W'(MAX_NODES);
			nv_q    <= '0;
			k_q     <= '0;
			s_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			i_q     <= '0;
			clr_q   <= '0;
		end else begin
			if (node_count_we) begin
				nc_q <= node_count;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + EDGE_AW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start && cmd == CMD_RUN) begin
						nv_q    <= (nc_q > LVL_W'(MAX_NODES)) ? LVL_W'(MAX_NODES) : nc_q;
						a_q     <= '0;
						state_q <= (nc_q == '0) ? ST_O_INIT : ST_INIT;
					end
				end
				ST_INIT: begin
					a_q <= a_q + NODE_W'(1);
					if (a_last) begin
						a_q     <= '0;
						b_q     <= '0;
						k_q     <= '0;
						state_q <= ST_B_RD;
					end
				end
				ST_B_RD: begin
					a_q <= a_q + NODE_W'(1);
					if (a_last) begin
						a_q     <= '0;
						state_q <= ST_B_WR;
					end
				end
				ST_B_WR: begin
					state_q <= ST_B_RD;
					b_q     <= b_q + NODE_W'(1);
					if (b_last) begin
						b_q <= '0;
						k_q <= k_q + LVL_W'(1);
						if (k_last) begin
							i_q     <= '0;
							state_q <= ST_SI_RD;
						end
					end
				end
				ST_SI_RD: state_q <= ST_SI_CHK;
				ST_SI_CHK: begin
					if (st.top_reach) begin
						s_q     <= nv_m1;
						state_q <= ST_SK_RD;
					end else if (i_last) begin
						state_q <= ST_O_INIT;
					end else begin
						i_q     <= i_q + NODE_W'(1);
						state_q <= ST_SI_RD;
					end
				end
				ST_SK_RD:  state_q <= ST_SK_EV;
				ST_SK_EV:  state_q <= ST_SK_MUL;
				ST_SK_MUL: state_q <= ST_SK_CMP;
				ST_SK_CMP: begin
					if (s_q != '0) begin
						s_q     <= s_q - LVL_W'(1);
						state_q <= ST_SK_RD;
					end else if (i_last) begin
						state_q <= ST_O_INIT;
					end else begin
						i_q     <= i_q + NODE_W'(1);
						state_q <= ST_SI_RD;
					end
				end
				ST_O_INIT: begin
					if (st.best_valid) begin
						s_q     <= nv_q;
						state_q <= ST_O_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_O_EMIT: state_q <= at_best ? ST_IDLE : ST_O_WAIT;
				ST_O_WAIT: begin
					s_q     <= s_q - LVL_W'(1);
					state_q <= ST_O_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl          = '0;
		ctl.clr_addr = clr_q;
		ctl.nv       = nv_q;
		ctl.k        = k_q;
		ctl.a        = a_q;
		ctl.b        = b_q;
		ctl.s        = s_q;
		ctl.i        = i_q;
		case (state_q)
			ST_CLEAR:  ctl.clr_we = 1'b1;
			ST_IDLE: begin
				ctl.edge_we  = start && cmd == CMD_EDGE;
				ctl.best_clr = start && cmd == CMD_RUN;
			end
			ST_INIT:   ctl.init_we = 1'b1;
			ST_B_RD: begin
				ctl.bld_rd    = 1'b1;
				ctl.bld_first = (a_q == '0);
			end
			ST_B_WR:   ctl.bld_wr = 1'b1;
			ST_SI_RD:  ctl.top_rd = 1'b1;
			ST_SI_CHK: begin
				ctl.top_ld   = 1'b1;
				ctl.cur_ld_i = 1'b1;
			end
			ST_SK_RD:  ctl.srch_rd = 1'b1;
			ST_SK_EV:  ctl.srch_ev = 1'b1;
			ST_SK_MUL: ctl.srch_mul = 1'b1;
			ST_SK_CMP: ctl.srch_cmp = 1'b1;
			ST_O_INIT: begin
				ctl.emit_none   = !st.best_valid;
				ctl.cur_ld_best = st.best_valid;
			end
			ST_O_EMIT: begin
				ctl.emit      = 1'b1;
				ctl.emit_last = at_best;
				ctl.out_rd    = !at_best;
			end
			ST_O_WAIT: ctl.out_cur_ld = 1'b1;
			default: ;
		endcase
	end

endmodule

### src/mmcf_dp.sv
// Datapath: edge store, walk cost and predecessor tables, min-plus step, ratio compare, output.
module mmcf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmcf_pkg::ctrl_t                   ctl,
	output mmcf_pkg::stat_t                   st,
	input  logic [mmcf_pkg::NODE_W-1:0]       from_node,
	input  logic [mmcf_pkg::NODE_W-1:0]       to_node,
	input  logic signed [mmcf_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                              edge_present,
	output logic                              result_valid,
	output logic                              found,
	output logic [mmcf_pkg::NODE_W-1:0]       cycle_node,
	output logic signed [mmcf_pkg::SUM_W-1:0] cycle_weight,
	output logic [mmcf_pkg::LVL_W-1:0]        cycle_length,
	output logic                              last
);
	import mmcf_pkg::*;

	// memories
	logic [WEIGHT_W:0] edge_mem [EDGE_DEPTH];
	logic [COST_W:0]   walk_mem [WALK_DEPTH];
	logic [NODE_W-1:0] pred_mem [WALK_DEPTH];

	logic [WEIGHT_W:0] edge_rd_q;
	logic [COST_W:0]   walk_rd_q;
	logic [NODE_W-1:0] pred_rd_q;

	logic               edge_we;
	logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
	logic [WEIGHT_W:0]  edge_wdata;
	logic               walk_we;
	logic [WALK_AW-1:0] walk_waddr, walk_raddr, pred_raddr;
	logic [COST_W:0]    walk_wdata;
	logic [LVL_W-1:0]   rd_lvl;
	logic [NODE_W-1:0]  rd_node;

	// build step
	logic                      rd_reach, edge_ok, step_ok;
	logic signed [COST_W-1:0]  rd_cost, step_cost;
	logic signed [WEIGHT_W-1:0] edge_w;
	logic                      rd_s1, first_s1;
	logic [NODE_W-1:0]         a_s1;
	logic                      acc_reach_q, acc_reach_n;
	logic signed [COST_W-1:0]  acc_cost_q, acc_cost_n;
	logic [NODE_W-1:0]         acc_pred_q, acc_pred_n;

	// search
	logic signed [COST_W-1:0]  top_cost_q;
	logic [NODE_W-1:0]         cur_q;
	logic signed [DIFF_W-1:0]  cand_na, cand_na_q;
	logic                      cand_pass_q;
	logic [LVL_W-1:0]          cand_len;
	logic signed [LVL_W:0]     cand_len_sx, best_len_sx;
	logic signed [PROD_W-1:0]  lhs_p, rhs_p, lhs_q, rhs_q;
	logic                      cand_ahead;
	logic                      best_valid_q;
	logic signed [DIFF_W-1:0]  best_na_q;
	logic [LVL_W-1:0]          best_len_q, best_k_q;
	logic [NODE_W-1:0]         best_i_q;

	assign edge_we    = ctl.clr_we | ctl.edge_we;
	assign edge_waddr = ctl.clr_we ? ctl.clr_addr : {from_node, to_node};
	assign edge_wdata = ctl.clr_we ? '0 : {edge_present, edge_weight};
	assign edge_raddr = {ctl.a, ctl.b};

	always_comb begin
		rd_lvl  = ctl.k;
		rd_node = ctl.a;
		if (ctl.top_rd) begin
			rd_lvl  = ctl.nv;
			rd_node = ctl.i;
		end else if (ctl.srch_rd) begin
			rd_lvl  = ctl.s;
			rd_node = ctl.i;
		end
	end

	assign walk_raddr = {rd_lvl, rd_node};
	assign walk_we    = ctl.init_we | ctl.bld_wr;
	assign walk_waddr = ctl.init_we ? {LVL_W'(0), ctl.a} : {ctl.k + LVL_W'(1), ctl.b};
	assign walk_wdata = ctl.init_we ? {1'b1, COST_W'(0)} : {acc_reach_n, acc_cost_n};
	assign pred_raddr = ctl.srch_rd ? {ctl.s + LVL_W'(1), cur_q} : {ctl.s, cur_q};

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_waddr] <= edge_wdata;
		end
		edge_rd_q <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (walk_we) begin
			walk_mem[walk_waddr] <= walk_wdata;
		end
		walk_rd_q <= walk_mem[walk_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.bld_wr) begin
			pred_mem[walk_waddr] <= acc_pred_n;
		end
		if (ctl.srch_rd || ctl.out_rd) begin
			pred_rd_q <= pred_mem[pred_raddr];
		end
	end

	// min-plus relaxation over source nodes; ties keep the lowest source
	assign rd_reach  = walk_rd_q[COST_W];
	assign rd_cost   = $signed(walk_rd_q[COST_W-1:0]);
	assign edge_ok   = edge_rd_q[WEIGHT_W];
	assign edge_w    = $signed(edge_rd_q[WEIGHT_W-1:0]);
	assign step_ok   = rd_reach & edge_ok;
	assign step_cost = rd_cost + $signed({{(COST_W-WEIGHT_W){edge_w[WEIGHT_W-1]}}, edge_w});

	always_comb begin
		acc_reach_n = acc_reach_q;
		acc_cost_n  = acc_cost_q;
		acc_pred_n  = acc_pred_q;
		if (first_s1 || (step_ok && (!acc_reach_q || step_cost < acc_cost_q))) begin
			acc_reach_n = step_ok;
			acc_cost_n  = step_cost;
			acc_pred_n  = a_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctl.bld_rd;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.bld_first;
		a_s1     <= ctl.a;
		if (rd_s1) begin
			acc_reach_q <= acc_reach_n;
			acc_cost_q  <= acc_cost_n;
			acc_pred_q  <= acc_pred_n;
		end
	end

	// candidate (k = s, node i): mean = cand_na / cand_len, compared by cross products
	assign cand_na     = DIFF_W'(top_cost_q) - DIFF_W'(rd_cost);
	assign cand_len    = ctl.nv - ctl.s;
	assign cand_len_sx = $signed({1'b0, cand_len});
	assign best_len_sx = $signed({1'b0, best_len_q});
	assign lhs_p       = cand_na_q * best_len_sx;
	assign rhs_p       = best_na_q * cand_len_sx;
	assign cand_ahead  = (lhs_q < rhs_q) ||
	                     (lhs_q == rhs_q && (ctl.s > best_k_q ||
	                                         (ctl.s == best_k_q && ctl.i < best_i_q)));

	always_ff @(posedge clk) begin
		if (ctl.top_ld) begin
			top_cost_q <= rd_cost;
		end
		if (ctl.cur_ld_i) begin
			cur_q <= ctl.i;
		end else if (ctl.cur_ld_best) begin
			cur_q <= best_i_q;
		end else if (ctl.srch_ev || ctl.out_cur_ld) begin
			cur_q <= pred_rd_q;
		end
		if (ctl.srch_ev) begin
			cand_na_q   <= cand_na;
			cand_pass_q <= rd_reach && (pred_rd_q == ctl.i);
		end
		if (ctl.srch_mul) begin
			lhs_q <= lhs_p;
			rhs_q <= rhs_p;
		end
		if (ctl.srch_cmp && cand_pass_q && (!best_valid_q || cand_ahead)) begin
			best_na_q  <= cand_na_q;
			best_len_q <= cand_len;
			best_k_q   <= ctl.s;
			best_i_q   <= ctl.i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (ctl.best_clr) begin
			best_valid_q <= 1'b0;
		end else if (ctl.srch_cmp && cand_pass_q) begin
			best_valid_q <= 1'b1;
		end
	end

	assign st.top_reach  = rd_reach;
	assign st.best_valid = best_valid_q;
	assign st.best_k     = best_k_q;

	// result register, one cycle per strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctl.emit | ctl.emit_none;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_none) begin
			found        <= 1'b0;
			cycle_node   <= '0;
			cycle_weight <= '0;
			cycle_length <= '0;
			last         <= 1'b1;
		end else if (ctl.emit) begin
			found        <= 1'b1;
			cycle_node   <= cur_q;
			cycle_weight <= best_na_q[SUM_W-1:0];
			cycle_length <= best_len_q;
			last         <= ctl.emit_last;
		end
	end

endmodule

### tb/mmcf_checker.sv
`timescale 1ns / 1ps
// Transfer monitor, cycle predictor and result comparator for the mean cycle finder.
module mmcf_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic                                 cmd,
	input  logic [mmcf_pkg::NODE_W-1:0]          from_node,
	input  logic [mmcf_pkg::NODE_W-1:0]          to_node,
	input  logic signed [mmcf_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                 edge_present,
	input  logic                                 node_count_we,
	input  logic [mmcf_pkg::LVL_W-1:0]           node_count,
	input  logic                                 result_valid,
	input  logic                                 found,
	input  logic [mmcf_pkg::NODE_W-1:0]          cycle_node,
	input  logic signed [mmcf_pkg::SUM_W-1:0]    cycle_weight,
	input  logic [mmcf_pkg::LVL_W-1:0]           cycle_length,
	input  logic                                 last,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   search_count,
	output int                                   hit_count
);
	import mmcf_pkg::*;

	typedef struct {
		logic              found;
		logic [NODE_W-1:0] node;
		logic [SUM_W-1:0]  wsum;
		logic [LVL_W-1:0]  len;
		logic              last;
	} cyc_res_t;

	cyc_res_t    cycle_q[$];
	logic [LVL_W-1:0] cfg_nodes;
	bit          arc_on[EDGE_DEPTH];
	longint      arc_w[EDGE_DEPTH];
	longint      walk_d[MAX_NODES+1][MAX_NODES];
	int          via[MAX_NODES+1][MAX_NODES];
	bit          seen[MAX_NODES+1][MAX_NODES];

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// exact ratio ordering by cross-multiplication
	function automatic bit ranks_ahead(int nv, int ka, int ia, int kb, int ib);
		longint na, nb, lhs, rhs;
		na = walk_d[nv][ia] - walk_d[ka][ia];
		nb = walk_d[nv][ib] - walk_d[kb][ib];
		lhs = na * (nv - kb);
		rhs = nb * (nv - ka);
		if (lhs != rhs) return lhs < rhs;
		if (ka != kb) return ka > kb;
		return ia < ib;
	endfunction

	function automatic bit closes_loop(int nv, int k, int i);
		int cur;
		cur = i;
		for (int s = nv; s > k; s--) cur = via[s][cur];
		return cur == i;
	endfunction

	task automatic solve_cycle();
		int nv, bk, bi, cur;
		bit have;
		longint c;
		cyc_res_t r;
		nv = (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
		have = 0; bk = 0; bi = 0;
		search_count++;
		if (nv > 0) begin
			foreach (seen[k, a]) seen[k][a] = 0;
			for (int a = 0; a < nv; a++) begin
				walk_d[0][a] = 0;
				via[0][a] = 0;
				seen[0][a] = 1;
			end
			for (int k = 0; k < nv; k++)
				for (int a = 0; a < nv; a++) begin
					if (!seen[k][a]) continue;
					for (int b = 0; b < nv; b++) begin
						if (!arc_on[a*MAX_NODES+b]) continue;
						c = walk_d[k][a] + arc_w[a*MAX_NODES+b];
						if (!seen[k+1][b] || c < walk_d[k+1][b]) begin
							walk_d[k+1][b] = c;
							via[k+1][b] = a;
							seen[k+1][b] = 1;
						end
					end
				end
			for (int i = 0; i < nv; i++) begin
				if (!seen[nv][i]) continue;
				for (int k = 0; k < nv; k++) begin
					if (!seen[k][i] || !closes_loop(nv, k, i)) continue;
					if (!have || ranks_ahead(nv, k, i, bk, bi)) begin
						have = 1; bk = k; bi = i;
					end
				end
			end
		end
		if (!have) begin
			r = '{found: 0, node: 0, wsum: 0, len: 0, last: 1};
			cycle_q = {cycle_q, r};
			return;
		end
		hit_count++;
		r.found = 1;
		r.wsum = SUM_W'(walk_d[nv][bi] - walk_d[bk][bi]);
		r.len = LVL_W'(nv - bk);
		r.last = 0;
		cur = bi;
		for (int s = nv; s > bk; s--) begin
			r.node = NODE_W'(cur);
			cycle_q = {cycle_q, r};
			cur = via[s][cur];
		end
		r.node = NODE_W'(bi);
		r.last = 1;
		cycle_q = {cycle_q, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		cyc_res_t e;
		if (!arst_n) begin
			cfg_nodes = MAX_NODES;
			foreach (arc_on[x]) arc_on[x] = 0;
			cycle_q.delete();
		end else begin
			if (result_valid) begin
				if (cycle_q.size() == 0) begin
					report("unexpected result, cycle_node", cycle_node, 0);
				end else begin
					e = cycle_q.pop_front();
					if (found !== e.found) report("found", found, e.found);
					if (cycle_node !== e.node) report("cycle_node", cycle_node, e.node);
					if (cycle_weight !== e.wsum)
						report("cycle_weight", cycle_weight, $signed(e.wsum));
					if (cycle_length !== e.len) report("cycle_length", cycle_length, e.len);
					if (last !== e.last) report("last", last, e.last);
				end
			end
			if (start && !busy) begin
				if (cmd == CMD_EDGE) begin
					arc_on[{from_node, to_node}] = edge_present;
					arc_w[{from_node, to_node}] = edge_weight;
				end else begin
					solve_cycle();
				end
			end
			// a register write lands after a run taken at the same edge
			if (node_count_we) cfg_nodes = node_count;
		end
		pending = cycle_q.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
		search_count = 0;
		hit_count = 0;
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus, clock/reset and verdict for the mean cycle finder testbench.
module tb_top;
	import mmcf_pkg::*;

	// cycles with no transfer and no result before giving up
	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;

	logic clk, arst_n, start, busy, cmd, edge_present, node_count_we;
	logic [NODE_W-1:0] from_node, to_node;
	logic signed [WEIGHT_W-1:0] edge_weight;
	logic [LVL_W-1:0] node_count;
	logic result_valid, found, last;
	logic [NODE_W-1:0] cycle_node;
	logic signed [SUM_W-1:0] cycle_weight;
	logic [LVL_W-1:0] cycle_length;
	int fail_count, pending, search_count, hit_count;
	int idle_pct;
	int stall_cycles;
	int sent;

	min_mean_cycle_finder_core dut (.*);

	mmcf_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog: any transfer or result restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", stall_cycles);
			$display("min_mean_cycle_finder_core verification failed");
			$finish;
		end
	end

	// one transfer; each cycle idles with probability idle_pct percent first
	task automatic send(input logic c, input int f, input int t, input logic signed [31:0] w,
			input logic p);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		from_node <= NODE_W'(f);
		to_node <= NODE_W'(t);
		edge_weight <= w;
		edge_present <= p;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic put_edge(int f, int t, logic signed [31:0] w);
		send(CMD_EDGE, f, t, w, 1'b1);
	endtask

	task automatic run_search();
		send(CMD_RUN, $urandom_range(31), $urandom_range(31), $urandom, $urandom_range(1));
	endtask

	// stop sending, let every result land, then give the block time to settle
	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_nodes(int v);
		quiesce();
		node_count_we <= 1'b1;
		node_count <= LVL_W'(v);
		@(negedge clk);
		node_count_we <= 1'b0;
	endtask

	// random edges mostly inside the active node range, mixed weight scales
	task automatic random_phase(int v, int n_items, int run_pct);
		int span, f, t;
		logic signed [31:0] w;
		span = (v > MAX_NODES) ? MAX_NODES : ((v < 1) ? 1 : v);
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(99) < run_pct) begin
				run_search();
				continue;
			end
			if ($urandom_range(9) == 0) begin
				f = $urandom_range(31);
				t = $urandom_range(31);
			end else begin
				f = $urandom_range(span - 1);
				t = ($urandom_range(4) == 0) ? f : $urandom_range(span - 1);
			end
			case ($urandom_range(3))
				0: w = $urandom;
				1: w = $signed($urandom_range(2000)) - 1000;
				default: w = $signed($urandom_range(40)) - 20;
			endcase
			send(CMD_EDGE, f, t, w, $urandom_range(7) != 0);
		end
		run_search();
	endtask

	initial begin
		int big_sizes[3];
		big_sizes = '{32, 40, 63};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_EDGE;
		from_node = '0;
		to_node = '0;
		edge_weight = '0;
		edge_present = 1'b0;
		node_count_we = 1'b0;
		node_count = '0;
		stall_cycles = 0;
		sent = 0;
		idle_pct = 13;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// clearing sweep after reset
		do @(negedge clk); while (busy);

		// directed: empty graph at full size, then small hand-built graphs
		run_search();
		set_nodes(4);
		put_edge(0, 1, 32'sh7FFF_FFFF);
		put_edge(1, 0, 32'sh8000_0000);
		put_edge(2, 2, 5);
		put_edge(31, 31, -100);           // outside the active nodes, stays stored
		put_edge(3, 31, -7);
		run_search();
		send(CMD_EDGE, 2, 2, 0, 1'b0);   // removal
		put_edge(2, 3, -3);
		put_edge(3, 2, -4);
		put_edge(1, 1, 32'sh8000_0000);
		run_search();
		set_nodes(0);                      // zero nodes: found=0
		run_search();
		set_nodes(1);
		run_search();                      // one node, no self loop
		put_edge(0, 0, -9);
		run_search();
		set_nodes(2);
		put_edge(0, 1, 3);
		put_edge(1, 0, 3);
		put_edge(0, 0, 3);                 // tie on mean
		run_search();

		random_phase(3, 30, 12);
		random_phase(5, 30, 10);
		idle_pct = 62;
		set_nodes(6);
		random_phase(6, 30, 10);
		set_nodes(2);
		random_phase(2, 25, 15);
		set_nodes(8);
		random_phase(8, 30, 8);
		idle_pct = 0;
		set_nodes(4);
		random_phase(4, 30, 12);
		set_nodes(7);
		random_phase(7, 30, 8);
		set_nodes(big_sizes[$urandom_range(2)]);
		random_phase(32, 40, 0);
		set_nodes(63);
		random_phase(32, 8, 0);
		set_nodes(1);
		random_phase(1, 15, 20);

		quiesce();
		$display("covered %0d transfers, %0d cycle searches (%0d with a cycle)",
			sent, search_count, hit_count);
		$display("node counts from 0 to 63, idle gaps at 13, 62 and 0 percent");
		if (fail_count == 0) begin
			$display("min_mean_cycle_finder_core verification clean");
		end else begin
			$display("min_mean_cycle_finder_core verification failed");
		end
		$finish;
	end

endmodule
